// ===== rtl/lsi_pkg.sv =====
`timescale 1ns / 1ps
// Shared package for the LMS system identifier: field widths, register indexes,
// reset values and the command and status types between controller and datapath.
// No dependencies.
package lsi_pkg;

	localparam int ADAPT_TAPS_DEF = 256;
	localparam int FIXED_TAPS_DEF = 5;

	localparam int SAMPLE_W = 16;
	localparam int OUT_W = 18;
	localparam int WEIGHT_W = 48;
	localparam int WSPLIT = 24;
	localparam int WFRAC = 40;
	localparam int CFRAC = 15;
	localparam int MU_W = 6;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam int NUM_COEFF_REGS = 5;

	localparam logic [CFG_IDX_W-1:0] REG_MU_SHIFT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FIXED_COEFF_0 = 3'd1;

	localparam logic [MU_W-1:0] MU_RESET = 6'd40;
	localparam logic signed [SAMPLE_W-1:0] COEFF_RESET = 16'sd6554;
	localparam logic signed [OUT_W-1:0] OUT_MAX = 18'sd131071;
	localparam logic signed [OUT_W-1:0] OUT_MIN = -18'sd131072;

	typedef struct packed {
		logic clear;
		logic push;
		logic rewind;
		logic mac_issue;
		logic upd_issue;
		logic fin1;
		logic fin2;
		logic load_out;
	} lsi_cmd_t;

	typedef struct packed {
		logic last_pass;
		logic last_taps;
	} lsi_status_t;

endpackage

// ===== rtl/lsi_ctrl.sv =====
`timescale 1ns / 1ps
// Controller for the LMS system identifier: sequences the clearing pass, the
// filter pass, the result and the weight update. Depends on lsi_pkg.
module lsi_ctrl import lsi_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	output logic        out_valid,
	input  logic        out_stall,
	input  lsi_status_t status,
	output lsi_cmd_t    cmd
);

	typedef enum logic [11:0] {
		ST_CLEAR  = 12'b000000000001,
		ST_IDLE   = 12'b000000000010,
		ST_MAC    = 12'b000000000100,
		ST_MAC_D1 = 12'b000000001000,
		ST_MAC_D2 = 12'b000000010000,
		ST_FIN1   = 12'b000000100000,
		ST_FIN2   = 12'b000001000000,
		ST_RESULT = 12'b000010000000,
		ST_UPD    = 12'b000100000000,
		ST_UPD_D1 = 12'b001000000000,
		ST_UPD_D2 = 12'b010000000000,
		ST_UPD_D3 = 12'b100000000000
	} lsi_state_t;

	lsi_state_t state_q, state_d;
	logic out_valid_q;
	logic out_free;

	assign out_free = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (status.last_taps) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.push = 1'b1;
					state_d = ST_MAC;
				end
			end
			ST_MAC: begin
				cmd.mac_issue = 1'b1;
				if (status.last_pass) begin
					state_d = ST_MAC_D1;
				end
			end
			ST_MAC_D1: begin
				state_d = ST_MAC_D2;
			end
			ST_MAC_D2: begin
				state_d = ST_FIN1;
			end
			ST_FIN1: begin
				cmd.fin1 = 1'b1;
				cmd.rewind = 1'b1;
				state_d = ST_FIN2;
			end
			ST_FIN2: begin
				cmd.fin2 = 1'b1;
				state_d = ST_RESULT;
			end
			ST_RESULT: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d = ST_UPD;
				end
			end
			ST_UPD: begin
				cmd.upd_issue = 1'b1;
				if (status.last_taps) begin
					state_d = ST_UPD_D1;
				end
			end
			ST_UPD_D1: begin
				state_d = ST_UPD_D2;
			end
			ST_UPD_D2: begin
				state_d = ST_UPD_D3;
			end
			ST_UPD_D3: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/lsi_datapath.sv =====
`timescale 1ns / 1ps
// Datapath for the LMS system identifier: configuration registers, delay lines,
// weight memory, the multiply-accumulate and update pipelines. Depends on lsi_pkg.
module lsi_datapath import lsi_pkg::*; #(
	parameter int ADAPT_TAPS = ADAPT_TAPS_DEF,
	parameter int FIXED_TAPS = FIXED_TAPS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  lsi_cmd_t                     cmd,
	output lsi_status_t                  status,
	input  logic                         cfg_write,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_data,
	input  logic signed [SAMPLE_W-1:0]   probe_sample,
	input  logic signed [SAMPLE_W-1:0]   measured_sample,
	output logic signed [SAMPLE_W-1:0]   fixed_out,
	output logic signed [OUT_W-1:0]      adaptive_out,
	output logic signed [OUT_W-1:0]      error_out
);

	localparam int PASS_LEN = (ADAPT_TAPS > FIXED_TAPS) ? ADAPT_TAPS : FIXED_TAPS;
	localparam int CW = $clog2(PASS_LEN);
	localparam int AW = $clog2(ADAPT_TAPS);
	localparam int FIW = (FIXED_TAPS > 1) ? $clog2(FIXED_TAPS) : 1;
	localparam int HI_W = WEIGHT_W - WSPLIT;
	localparam int PH_W = HI_W + SAMPLE_W;
	localparam int PL_W = WSPLIT + 1 + SAMPLE_W;
	localparam int SH_W = PH_W + AW;
	localparam int SL_W = PL_W + AW;
	localparam int TOT_W = WEIGHT_W + SAMPLE_W + AW;
	localparam int AF_W = TOT_W - WFRAC + 1;
	localparam int PF_W = 2 * SAMPLE_W;
	localparam int FS_W = PF_W + FIW;
	localparam int FT_W = FS_W - CFRAC + 1;
	localparam int PU_W = OUT_W + SAMPLE_W;

	logic [WEIGHT_W-1:0] wmem [ADAPT_TAPS];
	logic [SAMPLE_W-1:0] dmem [ADAPT_TAPS];

	logic [MU_W-1:0] mu_q;
	logic signed [SAMPLE_W-1:0] coeff_q [FIXED_TAPS];
	logic signed [SAMPLE_W-1:0] fdel_q [FIXED_TAPS];
	logic [CFG_IDX_W-1:0] coeff_sel;

	logic [CW-1:0] cnt_q;
	logic [AW-1:0] head_q, dptr_q, head_inc, dptr_dec, waddr;
	logic [FIW-1:0] fidx;
	logic tap_in, fix_in, rd_en;

	logic [WEIGHT_W-1:0] w_rd_s1;
	logic signed [SAMPLE_W-1:0] d_rd_s1, fcoef_s1, fdel_s1;
	logic mac_v_s1, fix_v_s1, upd_v_s1;
	logic [AW-1:0] waddr_s1;

	logic signed [PH_W-1:0] ph_s2;
	logic signed [PL_W-1:0] pl_s2;
	logic signed [PF_W-1:0] pf_s2;
	logic signed [PU_W-1:0] pu_s2;
	logic signed [WEIGHT_W-1:0] w_s2;
	logic mac_v_s2, fix_v_s2, upd_v_s2;
	logic [AW-1:0] waddr_s2;

	logic signed [PU_W-1:0] us_s3;
	logic signed [WEIGHT_W-1:0] w_s3;
	logic upd_v_s3;
	logic [AW-1:0] waddr_s3;
	logic signed [WEIGHT_W:0] w_sum;
	logic [WEIGHT_W-1:0] w_new;

	logic signed [SH_W-1:0] sh_q;
	logic signed [SL_W-1:0] sl_q;
	logic signed [FS_W-1:0] fs_q;
	logic signed [TOT_W-1:0] tot_q;
	logic signed [SAMPLE_W-1:0] meas_q;
	logic signed [OUT_W-1:0] a_q, e_q;

	logic signed [AF_W-1:0] a_full;
	logic signed [OUT_W-1:0] a_sat;
	logic signed [OUT_W:0] e_full;
	logic signed [FT_W-1:0] f_trunc;

	assign waddr = cnt_q[AW-1:0];
	assign fidx = cnt_q[FIW-1:0];
	assign tap_in = {1'b0, cnt_q} < (CW+1)'(ADAPT_TAPS);
	assign fix_in = {1'b0, cnt_q} < (CW+1)'(FIXED_TAPS);
	assign rd_en = (cmd.mac_issue && tap_in) || cmd.upd_issue;
	assign head_inc = (head_q == AW'(ADAPT_TAPS - 1)) ? '0 : head_q + 1'b1;
	assign dptr_dec = (dptr_q == '0) ? AW'(ADAPT_TAPS - 1) : dptr_q - 1'b1;

	assign status.last_pass = (cnt_q == CW'(PASS_LEN - 1));
	assign status.last_taps = (cnt_q == CW'(ADAPT_TAPS - 1));

	assign coeff_sel = cfg_index - REG_FIXED_COEFF_0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mu_q <= MU_RESET;
			for (int j = 0; j < FIXED_TAPS; j++) begin
				coeff_q[j] <= COEFF_RESET;
			end
		end else if (cfg_write) begin
			if (cfg_index == REG_MU_SHIFT) begin
				mu_q <= cfg_data[MU_W-1:0];
			end else if (cfg_index >= REG_FIXED_COEFF_0 &&
					cfg_index < REG_FIXED_COEFF_0 + CFG_IDX_W'(NUM_COEFF_REGS)) begin
				for (int j = 0; j < FIXED_TAPS; j++) begin
					if (int'(coeff_sel) == j) begin
						coeff_q[j] <= cfg_data[SAMPLE_W-1:0];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			head_q <= '0;
			dptr_q <= '0;
			for (int j = 0; j < FIXED_TAPS; j++) begin
				fdel_q[j] <= '0;
			end
		end else begin
			if (cmd.push || cmd.rewind) begin
				cnt_q <= '0;
			end else if (cmd.clear || cmd.mac_issue || cmd.upd_issue) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.push) begin
				head_q <= head_inc;
				dptr_q <= head_inc;
				fdel_q[0] <= probe_sample;
				for (int j = 1; j < FIXED_TAPS; j++) begin
					fdel_q[j] <= fdel_q[j-1];
				end
			end else if (cmd.rewind) begin
				dptr_q <= head_q;
			end else if (cmd.mac_issue || cmd.upd_issue) begin
				dptr_q <= dptr_dec;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clear) begin
			wmem[waddr] <= '0;
		end else if (upd_v_s3) begin
			wmem[waddr_s3] <= w_new;
		end
		if (cmd.clear) begin
			dmem[waddr] <= '0;
		end else if (cmd.push) begin
			dmem[head_inc] <= probe_sample;
		end
		if (rd_en) begin
			w_rd_s1 <= wmem[waddr];
			d_rd_s1 <= dmem[dptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mac_v_s1 <= 1'b0;
			fix_v_s1 <= 1'b0;
			upd_v_s1 <= 1'b0;
			mac_v_s2 <= 1'b0;
			fix_v_s2 <= 1'b0;
			upd_v_s2 <= 1'b0;
			upd_v_s3 <= 1'b0;
		end else begin
			mac_v_s1 <= cmd.mac_issue && tap_in;
			fix_v_s1 <= cmd.mac_issue && fix_in;
			upd_v_s1 <= cmd.upd_issue;
			mac_v_s2 <= mac_v_s1;
			fix_v_s2 <= fix_v_s1;
			upd_v_s2 <= upd_v_s1;
			upd_v_s3 <= upd_v_s2;
		end
	end

	always_ff @(posedge clk) begin
		waddr_s1 <= waddr;
		fcoef_s1 <= coeff_q[fidx];
		fdel_s1 <= fdel_q[fidx];

		ph_s2 <= $signed(w_rd_s1[WEIGHT_W-1:WSPLIT]) * d_rd_s1;
		pl_s2 <= $signed({1'b0, w_rd_s1[WSPLIT-1:0]}) * d_rd_s1;
		pf_s2 <= fcoef_s1 * fdel_s1;
		pu_s2 <= e_q * d_rd_s1;
		w_s2 <= w_rd_s1;
		waddr_s2 <= waddr_s1;

		us_s3 <= pu_s2 >>> mu_q;
		w_s3 <= w_s2;
		waddr_s3 <= waddr_s2;
	end

	always_comb begin
		w_sum = (WEIGHT_W+1)'(w_s3) + (WEIGHT_W+1)'(us_s3);
		if (w_sum[WEIGHT_W] != w_sum[WEIGHT_W-1]) begin
			w_new = {w_sum[WEIGHT_W], {(WEIGHT_W-1){~w_sum[WEIGHT_W]}}};
		end else begin
			w_new = w_sum[WEIGHT_W-1:0];
		end
	end

	always_comb begin
		a_full = AF_W'($signed(tot_q[TOT_W-1:WFRAC])) +
			AF_W'(tot_q[TOT_W-1] && (|tot_q[WFRAC-1:0]));
		if (a_full > AF_W'(OUT_MAX)) begin
			a_sat = OUT_MAX;
		end else if (a_full < AF_W'(OUT_MIN)) begin
			a_sat = OUT_MIN;
		end else begin
			a_sat = a_full[OUT_W-1:0];
		end
		e_full = (OUT_W+1)'(meas_q) - (OUT_W+1)'(a_sat);
		f_trunc = FT_W'($signed(fs_q[FS_W-1:CFRAC])) +
			FT_W'(fs_q[FS_W-1] && (|fs_q[CFRAC-1:0]));
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			meas_q <= measured_sample;
			sh_q <= '0;
			sl_q <= '0;
			fs_q <= '0;
		end else begin
			if (mac_v_s2) begin
				sh_q <= sh_q + SH_W'(ph_s2);
				sl_q <= sl_q + SL_W'(pl_s2);
			end
			if (fix_v_s2) begin
				fs_q <= fs_q + FS_W'(pf_s2);
			end
		end
		if (cmd.fin1) begin
			tot_q <= (TOT_W'(sh_q) <<< WSPLIT) + TOT_W'(sl_q);
		end
		if (cmd.fin2) begin
			a_q <= a_sat;
			if (e_full > (OUT_W+1)'(OUT_MAX)) begin
				e_q <= OUT_MAX;
			end else if (e_full < (OUT_W+1)'(OUT_MIN)) begin
				e_q <= OUT_MIN;
			end else begin
				e_q <= e_full[OUT_W-1:0];
			end
		end
		if (cmd.load_out) begin
			fixed_out <= f_trunc[SAMPLE_W-1:0];
			adaptive_out <= a_q;
			error_out <= e_q;
		end
	end

endmodule

// ===== rtl/lms_system_identifier.sv =====
`timescale 1ns / 1ps
// Top level of the LMS system identifier: joins the controller and the datapath.
// Depends on lsi_pkg, lsi_ctrl and lsi_datapath.
//
// Each transfer in carries a probe sample and the measured response; each transfer
// out carries the fixed filter output, the adaptive filter output and the error.
// One item is in work at a time. The weight memory has one read port, and it is
// walked once for the filter sum and once for the weight update before the next
// item can be accepted. The result is offered once the filter pass ends and waits
// in an output register while the update runs. After reset, a clearing pass zeroes
// the delay line and weight memories before the first item is accepted.
// Configuration writes may be made at any time the block holds no item.
module lms_system_identifier import lsi_pkg::*; #(
	parameter int ADAPT_TAPS = ADAPT_TAPS_DEF,
	parameter int FIXED_TAPS = FIXED_TAPS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_write,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic signed [SAMPLE_W-1:0] probe_sample,
	input  logic signed [SAMPLE_W-1:0] measured_sample,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [SAMPLE_W-1:0] fixed_out,
	output logic signed [OUT_W-1:0]    adaptive_out,
	output logic signed [OUT_W-1:0]    error_out
);

	lsi_cmd_t cmd;
	lsi_status_t status;

	lsi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	lsi_datapath #(
		.ADAPT_TAPS (ADAPT_TAPS),
		.FIXED_TAPS (FIXED_TAPS)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.cfg_write       (cfg_write),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.probe_sample    (probe_sample),
		.measured_sample (measured_sample),
		.fixed_out       (fixed_out),
		.adaptive_out    (adaptive_out),
		.error_out       (error_out)
	);

endmodule
